>>> rtl/lkv_pkg.sv
// Shared constants, command and status types for the LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none
package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 32;
    localparam int DATA_BYTES  = 4;
    localparam int DATA_W      = 8 * DATA_BYTES;
    localparam int LEN_W       = 3;
    localparam int CAP_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam int IN_FIELDS_W  = KEY_BITS + DATA_W + LEN_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + DATA_W + LEN_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_REJECTED  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_PUT    = 2'd1,
        OP_REJECT = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [KEY_BITS-1:0]   key;
        logic [DATA_W-1:0]     data;
        logic [LEN_W-1:0]      len;
    } cmd_t;

endpackage
`default_nettype wire

>>> rtl/lkv_front.sv
// Front end: capacity register, request decode, length clamp and byte masking.
`timescale 1ns / 1ps
`default_nettype none
module lkv_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lkv_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]      cfg_data,
    input  logic                           q_full,
    output logic                           q_push,
    output lkv_pkg::cmd_t                  q_cmd,
    output logic [lkv_pkg::CNT_W-1:0]      cap_eff
);
    import lkv_pkg::*;

    logic [CAP_W-1:0]    capacity_reg;
    logic [CAP_W-1:0]    capacity_next;
    logic [KEY_BITS-1:0] in_key;
    logic [DATA_W-1:0]   in_data;
    logic [LEN_W-1:0]    in_len;
    logic [LEN_W-1:0]    len_clamped;

    assign cfg_ready = 1'b1;

    always_comb begin
        capacity_next = capacity_reg;
        if (cfg_valid) begin
            capacity_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    // capacity above the slot count acts as the slot count
    assign cap_eff = (capacity_reg > CAP_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                          : CNT_W'(capacity_reg);

    assign in_key  = s_tdata[KEY_BITS-1:0];
    assign in_data = s_tdata[KEY_BITS +: DATA_W];
    assign in_len  = s_tdata[KEY_BITS + DATA_W +: LEN_W];

    assign len_clamped = (in_len > LEN_W'(DATA_BYTES)) ? LEN_W'(DATA_BYTES) : in_len;

    always_comb begin
        q_cmd.key = in_key;
        q_cmd.len = len_clamped;
        for (int b = 0; b < DATA_BYTES; b++) begin
            q_cmd.data[8*b +: 8] = (LEN_W'(b) < len_clamped) ? in_data[8*b +: 8] : 8'd0;
        end
        priority if (s_tuser == FUNC_GET) begin
            q_cmd.kind = OP_GET;
        end else if (cap_eff == '0 || in_len == '0) begin
            q_cmd.kind = OP_REJECT;
        end else begin
            q_cmd.kind = OP_PUT;
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

endmodule
`default_nettype wire

>>> rtl/lkv_queue.sv
// Small command queue between the front end and the entry engine.
`timescale 1ns / 1ps
`default_nettype none
module lkv_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lkv_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output lkv_pkg::cmd_t pop_cmd,
    output logic          empty
);
    import lkv_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign full    = (level_reg == LVL_W'(QUEUE_DEPTH));
    assign empty   = (level_reg == '0);
    assign pop_cmd = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop) begin
            level_next = level_reg + LVL_W'(1);
        end else if (pop && !push) begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

>>> rtl/lkv_back.sv
// Entry engine: key match, LRU ranks, entry store update and result register.
`timescale 1ns / 1ps
`default_nettype none
module lkv_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_empty,
    input  lkv_pkg::cmd_t                   q_cmd,
    output logic                            q_pop,
    input  logic [lkv_pkg::CNT_W-1:0]       cap_eff,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lkv_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import lkv_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // entry store
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]       rank_reg  [MAX_ENTRIES];
    logic [IDX_W-1:0]       rank_next [MAX_ENTRIES];
    logic [KEY_BITS-1:0]    key_mem   [MAX_ENTRIES];
    logic [DATA_W-1:0]      data_mem  [MAX_ENTRIES];
    logic [LEN_W-1:0]       len_mem   [MAX_ENTRIES];
    logic [CNT_W-1:0]       count_reg, count_next;

    // lookup results held for the update cycle
    cmd_t             cmd_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] hit_rank_reg;
    logic [IDX_W-1:0] tgt_idx_reg;
    logic             grow_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [LEN_W-1:0]  out_len_reg;

    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] lru_vec;
    logic                   hit;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       hit_rank;
    logic [IDX_W-1:0]       lru_idx;
    logic [IDX_W-1:0]       free_idx;
    logic [CNT_W-1:0]       count_m1;
    logic                   evict;
    logic                   promote;
    logic                   insert;
    logic [IDX_W-1:0]       wr_idx;
    status_t                status_new;

    // ---- lookup, from the queue head ----
    assign count_m1 = count_reg - CNT_W'(1);

    always_comb begin
        hit_idx  = '0;
        hit_rank = '0;
        lru_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match_vec[i] = valid_reg[i] && (key_mem[i] == q_cmd.key);
            lru_vec[i]   = valid_reg[i] && (rank_reg[i] == count_m1[IDX_W-1:0]);
            if (match_vec[i]) begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
            if (lru_vec[i]) begin
                lru_idx = lru_idx | IDX_W'(i);
            end
        end
        // lowest free slot
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign hit   = |match_vec;
    assign evict = (count_reg >= cap_eff);
    assign q_pop = (state_reg == ST_IDLE) && !q_empty && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg      <= q_cmd;
            hit_reg      <= hit;
            hit_idx_reg  <= hit_idx;
            hit_rank_reg <= hit_rank;
            tgt_idx_reg  <= evict ? lru_idx : free_idx;
            grow_reg     <= !evict;
        end
    end

    // ---- update ----
    assign promote = (state_reg == ST_EXEC) && hit_reg
                     && (cmd_reg.kind == OP_GET || cmd_reg.kind == OP_PUT);
    assign insert  = (state_reg == ST_EXEC) && !hit_reg && (cmd_reg.kind == OP_PUT);
    assign wr_idx  = hit_reg ? hit_idx_reg : tgt_idx_reg;

    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        if (promote) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (valid_reg[i] && IDX_W'(i) != hit_idx_reg
                    && rank_reg[i] < hit_rank_reg) begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
            rank_next[hit_idx_reg] = '0;
        end else if (insert) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (valid_reg[i] && IDX_W'(i) != tgt_idx_reg) begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
            valid_next[tgt_idx_reg] = 1'b1;
            rank_next[tgt_idx_reg]  = '0;
            if (grow_reg) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC && cmd_reg.kind == OP_PUT) begin
            key_mem[wr_idx]  <= cmd_reg.key;
            data_mem[wr_idx] <= cmd_reg.data;
            len_mem[wr_idx]  <= cmd_reg.len;
        end
    end

    // ---- result ----
    always_comb begin
        unique case (cmd_reg.kind)
            OP_GET:    status_new = hit_reg ? STATUS_DONE : STATUS_NOT_FOUND;
            OP_PUT:    status_new = STATUS_DONE;
            OP_REJECT: status_new = STATUS_REJECTED;
            default:   status_new = STATUS_REJECTED;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (state_reg == ST_EXEC) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC) begin
            out_status_reg <= status_new;
            if (cmd_reg.kind == OP_GET && hit_reg) begin
                out_data_reg <= data_mem[hit_idx_reg];
                out_len_reg  <= len_mem[hit_idx_reg];
            end else begin
                out_data_reg <= '0;
                out_len_reg  <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_len_reg, out_data_reg, out_status_reg};

    // ---- checks ----
    a_count_tracks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == count_reg)
        else $error("entry count out of step with valid slots");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above slot count");

    a_pop_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg == ST_EXEC)
        else $error("popped command not executed next cycle");

    a_exec_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC |-> !out_valid_reg)
        else $error("result register still full at update");

    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result raised without an update");

endmodule
`default_nettype wire

>>> rtl/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key/value cache.
// A beat accepted passes the queue, the lookup registers and the result register to m_tvalid.
// The engine pops a request only when idle and its result register is free or being taken.
// The input side keeps taking beats into a two-deep queue while a result waits on m_tready.
// Reset: cache empty (all valid bits and the entry count cleared), capacity back to 16.
// No clearing pass: the key/data store is never read before it is written.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // request stream
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // s_tdata, low bit up: key[31:0], write_data[63:32], write_len[66:64], zero pad
    input  wire logic [lkv_pkg::IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: func (0 get, 1 put)
    input  wire logic                            s_tuser,
    // result stream
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata, low bit up: status[1:0], read_data[33:2], read_len[36:34], zero pad
    output      logic [lkv_pkg::OUT_TDATA_W-1:0] m_tdata,
    // capacity write channel
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [lkv_pkg::CAP_W-1:0]       cfg_data
);
    import lkv_pkg::*;

    cmd_t             push_cmd;
    cmd_t             head_cmd;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [CNT_W-1:0] cap_eff;

    // Front end decodes each beat, clamps the length, masks unused bytes and
    // flags puts that must be rejected, so the engine only sees clean commands.
    lkv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .cap_eff   (cap_eff)
    );

    // Decouples input acceptance from the engine and from output stalls.
    lkv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (head_cmd),
        .empty    (q_empty)
    );

    // Engine: the lookup at pop matches the key against all slots and picks the
    // victim or free slot; the EXEC state updates ranks/store and loads the result.
    lkv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .cap_eff  (cap_eff),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
